// ===== design/thrc_pkg.sv =====
package thrc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_DATA_W    = 22;
    localparam int CFG_IDX_W     = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLD      = 2'd2;

    localparam logic [15:0] TAP_THRESHOLD_RST = 16'd300;

    typedef enum logic [1:0] {
        ACT_KEY_DOWN = 2'd0,
        ACT_KEY_UP   = 2'd1,
        ACT_ESCAPE   = 2'd2,
        ACT_TICK     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_PTT    = 2'd0,
        MODE_TOGGLE = 2'd1,
        MODE_SMART  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_REC    = 2'd1,
        PH_STICKY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_START   = 2'd1,
        CMD_PROMOTE = 2'd2,
        CMD_STOP    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] machine_state;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  press_mode;
        logic [15:0] tap_threshold_ms;
        logic [21:0] max_hold_ms;
    } t_cfg;

endpackage

// ===== design/thrc_cfg_regs.sv =====
module thrc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [thrc_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  logic [thrc_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output thrc_pkg::t_cfg                    o_cfg
);
    import thrc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_mode       <= 2'd0;
            r_cfg.tap_threshold_ms <= TAP_THRESHOLD_RST;
            r_cfg.max_hold_ms      <= 22'd0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_PRESS_MODE:    r_cfg.press_mode       <= i_wr_data[1:0];
                CFG_TAP_THRESHOLD: r_cfg.tap_threshold_ms <= i_wr_data[15:0];
                CFG_MAX_HOLD:      r_cfg.max_hold_ms      <= i_wr_data[21:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/thrc_fsm.sv =====
module thrc_fsm #(
    parameter int TIME_BITS = thrc_pkg::TIME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  thrc_pkg::t_in_item  i_item,
    input  thrc_pkg::t_cfg      i_cfg,
    output thrc_pkg::t_out_item o_result
);
    import thrc_pkg::*;

    localparam int CMP_W = (TIME_BITS > 22) ? TIME_BITS : 22;

    t_phase               r_phase, n_phase;
    logic [TIME_BITS-1:0] r_press_time, n_press_time;
    t_cmd                 cmd;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] hold;
    logic [CMP_W-1:0]     hold_ext;
    logic                 is_tap;
    logic                 max_hit;

    assign now_t    = TIME_BITS'(i_item.now_ms);
    assign hold     = now_t - r_press_time;  // wraps modulo 2^TIME_BITS
    assign hold_ext = CMP_W'(hold);
    assign is_tap   = hold_ext < CMP_W'(i_cfg.tap_threshold_ms);
    assign max_hit  = (i_cfg.max_hold_ms != 22'd0) &&
                      (hold_ext >= CMP_W'(i_cfg.max_hold_ms));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_press_time <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_press_time <= n_press_time;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_press_time = r_press_time;
        cmd          = CMD_NONE;
        case (t_action'(i_item.action))
            ACT_KEY_DOWN: begin
                if (r_phase == PH_IDLE) begin
                    n_phase      = PH_REC;
                    n_press_time = now_t;
                    cmd          = CMD_START;
                end else if (r_phase == PH_STICKY) begin
                    n_phase = PH_IDLE;
                    cmd     = CMD_STOP;
                end
            end
            ACT_KEY_UP: begin
                if (r_phase == PH_REC) begin
                    case (t_mode'(i_cfg.press_mode))
                        MODE_PTT: begin
                            n_phase = PH_IDLE;
                            cmd     = CMD_STOP;
                        end
                        MODE_TOGGLE: begin
                            n_phase = PH_STICKY;
                            cmd     = CMD_PROMOTE;
                        end
                        MODE_SMART: begin
                            n_phase = is_tap ? PH_STICKY : PH_IDLE;
                            cmd     = is_tap ? CMD_PROMOTE : CMD_STOP;
                        end
                        default: ;  // unused mode: key up ignored
                    endcase
                end
            end
            ACT_ESCAPE: begin
                if (r_phase != PH_IDLE) begin
                    n_phase = PH_IDLE;
                    cmd     = CMD_STOP;
                end
            end
            default: begin  // tick
                if (r_phase != PH_IDLE && max_hit) begin
                    n_phase = PH_IDLE;
                    cmd     = CMD_STOP;
                end
            end
        endcase
    end

    assign o_result.command       = cmd;
    assign o_result.machine_state = n_phase;

endmodule

// ===== design/tap_hold_record_control_fsm_unit.sv =====
// Tap-or-hold record control.
// Turns key events (key down, key up, escape, tick) with ms timestamps into
// recording commands (none, start, promote to sticky, stop) plus the phase
// reached (idle, recording, sticky). Exactly one result beat per input beat.
// Channels: input beat i_in_valid/o_in_ready with i_in_data, result beat
// o_out_valid/i_out_ready with o_out_data, register writes on
// i_cfg_valid/o_cfg_ready (always ready) with i_cfg_index/i_cfg_data.
// Path: input register, then the state update and result register in the
// same cycle.
// Throughput: one beat per cycle unless the receiver stalls; phase and press
// time update as each beat advances, so back-to-back beats see that state.
// Receiver stall: the result register holds its beat, the input register
// fills with the next one, then o_in_ready drops until the result is taken.
// Reset (i_rst_n low, synchronous): both stages empty, phase idle, press
// time 0, press mode push-to-talk, tap threshold 300 ms, max hold disabled.
// Write registers only while no beat is in flight; the block does not check.
module tap_hold_record_control_fsm_unit #(
    parameter int TIME_BITS = thrc_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  thrc_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output thrc_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [thrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [thrc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import thrc_pkg::*;

    t_cfg      cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item result;
    logic      advance;

    assign o_cfg_ready = 1'b1;

    thrc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // beat moves from the input register to the result register
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    thrc_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

`ifndef NO_ASSERTIONS
    a_start_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.command == CMD_START)
            |-> o_out_data.machine_state == PH_REC)
        else $error("start beat not in recording phase");

    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.command == CMD_STOP)
            |-> o_out_data.machine_state == PH_IDLE)
        else $error("stop beat not in idle phase");

    a_promote_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.command == CMD_PROMOTE)
            |-> o_out_data.machine_state == PH_STICKY)
        else $error("promote beat not in sticky phase");

    a_stalled_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("held input beat lost");
`endif

endmodule

// ===== verif/tap_hold_record_control_fsm_unit_test.sv =====
module tap_hold_record_control_fsm_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import thrc_pkg::*;

    // Codes with no name in the package: the spare press mode and the
    // register index past the end of the map.
    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    localparam int ITEMS_PER_PHASE = 450;
    localparam int LONG_STALL      = 400;

    // ------------------------------------------------------------------
    // Clock, reset and the signals into the block, all known from time 0.
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      o_cfg_ready;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    tap_hold_record_control_fsm_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the control state and registers. Updated at the
    // edge where the beat or the register write is taken.
    // ------------------------------------------------------------------
    t_phase      fsm_phase = PH_IDLE;
    logic [31:0] press_ms  = '0;
    logic [1:0]  mode_reg  = MODE_PTT;
    logic [15:0] tap_ms    = TAP_THRESHOLD_RST;
    logic [21:0] max_ms    = '0;

    // Commands still owed by the block, oldest first.
    t_out_item pending_cmds[$];

    int bad_beats        = 0;
    int sender_idle_pct  = 0;
    int recv_stall_pct   = 0;
    int stall_left       = 0;   // forced receiver hold-off, in cycles
    int phase_beats      = 0;

    // Next command and phase for one key event; moves the shadow state on.
    function automatic t_out_item advance_fsm(input t_in_item ev);
        t_out_item   res;
        t_cmd        cmd;
        logic [31:0] held;
        cmd  = CMD_NONE;
        // hold is the wrapping distance from the press, read as unsigned
        held = ev.now_ms - press_ms;
        case (t_action'(ev.action))
            ACT_KEY_DOWN: begin
                if (fsm_phase == PH_IDLE) begin
                    fsm_phase = PH_REC;
                    press_ms  = ev.now_ms;
                    cmd       = CMD_START;
                end else if (fsm_phase == PH_STICKY) begin
                    fsm_phase = PH_IDLE;
                    cmd       = CMD_STOP;
                end
                // key down while recording is a key repeat: nothing
            end
            ACT_KEY_UP: begin
                if (fsm_phase == PH_REC) begin
                    case (mode_reg)
                        MODE_PTT: begin
                            fsm_phase = PH_IDLE;
                            cmd       = CMD_STOP;
                        end
                        MODE_TOGGLE: begin
                            fsm_phase = PH_STICKY;
                            cmd       = CMD_PROMOTE;
                        end
                        MODE_SMART: begin
                            if (held < {16'd0, tap_ms}) begin
                                fsm_phase = PH_STICKY;
                                cmd       = CMD_PROMOTE;
                            end else begin
                                fsm_phase = PH_IDLE;
                                cmd       = CMD_STOP;
                            end
                        end
                        default: ;  // spare mode: stays recording
                    endcase
                end
            end
            ACT_ESCAPE: begin
                if (fsm_phase != PH_IDLE) begin
                    fsm_phase = PH_IDLE;
                    cmd       = CMD_STOP;
                end
            end
            default: begin
                // tick: auto stop at max hold, zero max means never
                if (fsm_phase != PH_IDLE && max_ms != 0 && held >= {10'd0, max_ms}) begin
                    fsm_phase = PH_IDLE;
                    cmd       = CMD_STOP;
                end
            end
        endcase
        res.command       = cmd;
        res.machine_state = fsm_phase;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Each task starts on the negedge after the previous
    // accept, so valid is either replaced or dropped there, never both.
    // ------------------------------------------------------------------
    task automatic send_event(input t_in_item ev, input bit typed, input t_out_item want);
        t_out_item got;
        @(negedge i_clk);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        // taken at this edge; the shadow state moves with it
        got = advance_fsm(ev);
        pending_cmds.push_back(typed ? want : got);
    endtask

    task automatic offer(input logic [1:0] act, input logic [31:0] now);
        t_in_item ev;
        ev.action = act;
        ev.now_ms = now;
        send_event(ev, 1'b0, '0);
        phase_beats++;
    endtask

    // Drop valid and sit until the block has handed back every command.
    task automatic hold_until_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    // Drained plus the pipeline depth, so no beat is in flight.
    task automatic settle_block();
        hold_until_drained();
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [21:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PRESS_MODE:    mode_reg = val[1:0];
            CFG_TAP_THRESHOLD: tap_ms   = val[15:0];
            CFG_MAX_HOLD:      max_ms   = val;
            default: ;  // past the register map: ignored
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Random register value, biased toward the ends of each range; the
    // bits above the register width are left random to hit the masking.
    task automatic pick_config(input logic [1:0] idx);
        logic [21:0] v;
        int          sel;
        v   = 22'($urandom());
        sel = $urandom_range(3, 0);
        case (idx)
            CFG_PRESS_MODE:
                v[1:0] = ($urandom_range(9, 0) == 0) ? MODE_UNUSED : 2'($urandom_range(2, 0));
            CFG_TAP_THRESHOLD: begin
                case (sel)
                    0: v[15:0] = 16'd0;
                    1: v[15:0] = 16'hFFFF;
                    2: v[15:0] = 16'($urandom_range(1000, 1));
                    default: ;
                endcase
            end
            default: begin
                case (sel)
                    0: v = 22'd0;
                    1: v = 22'h3FFFFF;
                    2: v = 22'($urandom_range(3000, 1));
                    default: ;
                endcase
            end
        endcase
        cfg_write(idx, v);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, or a forced hold-off when asked.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Result checker: every taken beat against the oldest owed command.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_cmds.size() == 0) begin
                if (bad_beats < 10)
                    $display("unexpected result beat: command %0d state %0d",
                             o_out_data.command, o_out_data.machine_state);
                bad_beats++;
            end else begin
                want = pending_cmds.pop_front();
                if (o_out_data.command !== want.command ||
                    o_out_data.machine_state !== want.machine_state) begin
                    if (bad_beats < 10)
                        $display("mismatch: command exp %0d got %0d, state exp %0d got %0d",
                                 want.command, o_out_data.command,
                                 want.machine_state, o_out_data.machine_state);
                    bad_beats++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table. One row is either a register write or a key event;
    // typed rows carry their own expected command and phase, the others
    // go through the shadow model.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  cfg_idx;
        logic [21:0] cfg_val;
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic        typed;
        logic [1:0]  want_cmd;
        logic [1:0]  want_ph;
    } t_row;

    localparam int N_ROWS = 34;

    // cfg, idx, value, action, timestamp, typed, command, phase
    localparam t_row DIRECTED[N_ROWS] = '{
        // reset defaults: push-to-talk, tap 300, no max hold
        '{1'b0, 2'd0, 22'd0, ACT_KEY_UP,   32'd0,        1'b1, CMD_NONE,    PH_IDLE},
        '{1'b0, 2'd0, 22'd0, ACT_ESCAPE,   32'd0,        1'b1, CMD_NONE,    PH_IDLE},
        '{1'b0, 2'd0, 22'd0, ACT_TICK,     32'hFFFFFFFF, 1'b1, CMD_NONE,    PH_IDLE},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_DOWN, 32'd100,      1'b1, CMD_START,   PH_REC},
        // key repeat while recording
        '{1'b0, 2'd0, 22'd0, ACT_KEY_DOWN, 32'd150,      1'b1, CMD_NONE,    PH_REC},
        // tick with max hold disabled, longest possible hold
        '{1'b0, 2'd0, 22'd0, ACT_TICK,     32'hFFFFFFFF, 1'b1, CMD_NONE,    PH_REC},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_UP,   32'd200,      1'b1, CMD_STOP,    PH_IDLE},
        // toggle
        '{1'b1, CFG_PRESS_MODE, 22'd1, 2'd0, 32'd0, 1'b0, 2'd0, 2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_DOWN, 32'hFFFFFFFF, 1'b1, CMD_START,   PH_REC},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_UP,   32'd0,        1'b1, CMD_PROMOTE, PH_STICKY},
        // key up while sticky is ignored
        '{1'b0, 2'd0, 22'd0, ACT_KEY_UP,   32'd5,        1'b1, CMD_NONE,    PH_STICKY},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_DOWN, 32'd6,        1'b1, CMD_STOP,    PH_IDLE},
        // smart, written with junk above bit 1; tap at its top, junk above
        '{1'b1, CFG_PRESS_MODE,    22'h3FFFFE, 2'd0, 32'd0, 1'b0, 2'd0, 2'd0},
        '{1'b1, CFG_TAP_THRESHOLD, 22'h3FFFFF, 2'd0, 32'd0, 1'b0, 2'd0, 2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_DOWN, 32'hFFFFFFF0, 1'b1, CMD_START,   PH_REC},
        // release across the timestamp wrap: short hold, so a tap
        '{1'b0, 2'd0, 22'd0, ACT_KEY_UP,   32'h0000000F, 1'b0, 2'd0,        2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_ESCAPE,   32'd20,       1'b1, CMD_STOP,    PH_IDLE},
        // zero threshold: even a zero hold is not a tap
        '{1'b1, CFG_TAP_THRESHOLD, 22'd0, 2'd0, 32'd0, 1'b0, 2'd0, 2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_DOWN, 32'd5,        1'b1, CMD_START,   PH_REC},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_UP,   32'd5,        1'b0, 2'd0,        2'd0},
        // max hold at its top: one ms short, then exactly at it
        '{1'b1, CFG_MAX_HOLD, 22'h3FFFFF, 2'd0, 32'd0, 1'b0, 2'd0, 2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_DOWN, 32'd1000,     1'b1, CMD_START,   PH_REC},
        '{1'b0, 2'd0, 22'd0, ACT_TICK,     32'h004003E6, 1'b0, 2'd0,        2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_TICK,     32'h004003E7, 1'b0, 2'd0,        2'd0},
        // max hold of one, press at the top of the clock
        '{1'b1, CFG_MAX_HOLD, 22'd1, 2'd0, 32'd0, 1'b0, 2'd0, 2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_DOWN, 32'hFFFFFFFF, 1'b1, CMD_START,   PH_REC},
        '{1'b0, 2'd0, 22'd0, ACT_TICK,     32'hFFFFFFFF, 1'b0, 2'd0,        2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_TICK,     32'd0,        1'b0, 2'd0,        2'd0},
        // spare press mode: key up leaves recording alone
        '{1'b1, CFG_PRESS_MODE, 22'd3, 2'd0, 32'd0, 1'b0, 2'd0, 2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_DOWN, 32'd7,        1'b1, CMD_START,   PH_REC},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_UP,   32'd8,        1'b1, CMD_NONE,    PH_REC},
        // write past the map must change nothing
        '{1'b1, CFG_UNUSED_IDX, 22'h3FFFFF, 2'd0, 32'd0, 1'b0, 2'd0, 2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_KEY_UP,   32'd9,        1'b0, 2'd0,        2'd0},
        '{1'b0, 2'd0, 22'd0, ACT_ESCAPE,   32'd10,       1'b1, CMD_STOP,    PH_IDLE}
    };

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, then four random phases with
    // different idling, then drain and report.
    // ------------------------------------------------------------------
    initial begin
        t_in_item    ev;
        t_out_item   want;
        logic [31:0] clock_ms;
        logic [31:0] t0;
        logic [31:0] hold;
        logic [31:0] gap;
        bit          stalled;

        clock_ms = $urandom();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED[r].is_cfg) begin
                settle_block();
                cfg_write(DIRECTED[r].cfg_idx, DIRECTED[r].cfg_val);
            end else begin
                ev.action          = DIRECTED[r].action;
                ev.now_ms          = DIRECTED[r].now_ms;
                want.command       = DIRECTED[r].want_cmd;
                want.machine_state = DIRECTED[r].want_ph;
                send_event(ev, DIRECTED[r].typed, want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 72; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin sender_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            settle_block();
            pick_config(CFG_PRESS_MODE);
            pick_config(CFG_TAP_THRESHOLD);
            pick_config(CFG_MAX_HOLD);
            if ($urandom_range(1, 0) == 1)
                cfg_write(CFG_UNUSED_IDX, 22'($urandom()));
            phase_beats = 0;
            stalled     = 1'b0;

            while (phase_beats < ITEMS_PER_PHASE) begin
                // long receiver hold-off while the sender keeps pushing,
                // so the block fills up and drops its input ready
                if ((ph == 0 || ph == 2) && !stalled && phase_beats >= 100) begin
                    stall_left = LONG_STALL;
                    stalled    = 1'b1;
                end

                case ($urandom_range(99, 0))
                    0, 1:    hold_until_drained();
                    2, 3, 4: begin
                        settle_block();
                        pick_config(2'($urandom_range(2, 0)));
                    end
                    default: ;
                endcase

                if ($urandom_range(99, 0) < 75) begin
                    // one press: down, maybe a repeat, maybe a tick, mostly an up,
                    // then maybe a follow-up event. Holds sit around the tap
                    // threshold and the max hold to hit both edges.
                    case ($urandom_range(7, 0))
                        0:       hold = {16'd0, tap_ms} - 32'd1;
                        1:       hold = {16'd0, tap_ms};
                        2:       hold = {16'd0, tap_ms} + 32'd1;
                        3:       hold = {10'd0, max_ms} - 32'd1;
                        4:       hold = {10'd0, max_ms};
                        5:       hold = {10'd0, max_ms} + 32'd1;
                        6:       hold = $urandom_range(2000, 0);
                        default: hold = $urandom();
                    endcase
                    t0 = clock_ms;
                    offer(ACT_KEY_DOWN, t0);
                    if ($urandom_range(3, 0) == 0)
                        offer(ACT_KEY_DOWN, t0 + $urandom_range(40, 0));
                    if ($urandom_range(1, 0) == 1)
                        offer(ACT_TICK, t0 + hold);
                    if ($urandom_range(9, 0) != 0)
                        offer(ACT_KEY_UP, t0 + hold);
                    gap = $urandom_range(500, 0);
                    case ($urandom_range(3, 0))
                        0:       offer(ACT_KEY_DOWN, t0 + hold + gap);
                        1:       offer(ACT_ESCAPE, t0 + hold + gap);
                        2:       offer(ACT_TICK, t0 + hold + gap);
                        default: ;
                    endcase
                    clock_ms = t0 + hold + gap + $urandom_range(100, 1);
                end else begin
                    // noise: any action, timestamp near now or anywhere
                    if ($urandom_range(1, 0) == 1)
                        offer(2'($urandom_range(3, 0)), $urandom());
                    else
                        offer(2'($urandom_range(3, 0)), clock_ms + $urandom_range(300, 0));
                end
            end
        end

        settle_block();
        repeat (8) @(posedge i_clk);
        if (bad_beats == 0 && pending_cmds.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog, far past the slowest legal run.
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
